>>> hw/rtl/rmj_pkg.sv
`default_nettype none
package rmj_pkg;

  localparam int WORD_W = 32;
  localparam int WIDE_W = 64;
  localparam int DVD_W  = 96;
  localparam int QUO_W  = WORD_W + 1;
  localparam int ROOT_W = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [WIDE_W-1:0] wide_t;
  typedef logic [DVD_W-1:0]  dvd_t;

  localparam word_t POS_LIM = 32'h7fff_ffff;
  localparam word_t NEG_LIM = 32'h8000_0000;
  localparam word_t THR_RST = 32'd42950;

endpackage
`default_nettype wire

>>> hw/rtl/rmj_sqrt_pipe.sv
`default_nettype none
module rmj_sqrt_pipe
  import rmj_pkg::*;
#(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ce,
  input  logic            in_vld,
  input  wide_t           in_rad,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_vld,
  output logic [ROOT_W-1:0] out_root,
  output logic [SB_W-1:0] out_sb
);

  localparam int REM_W = ROOT_W + 3;
  localparam int STP_W = REM_W + ROOT_W + WIDE_W;

  // one root bit per stage, remainder never exceeds twice the partial root
  function automatic logic [STP_W-1:0] sqrt_step(input logic [REM_W-1:0] rem,
                                                 input logic [ROOT_W-1:0] root,
                                                 input wide_t rad);
    logic [REM_W-1:0]  t;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] nroot;
    t     = {rem[REM_W-3:0], rad[WIDE_W-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    if (t >= trial) begin
      t     = t - trial;
      nroot = {root[ROOT_W-2:0], 1'b1};
    end else begin
      nroot = {root[ROOT_W-2:0], 1'b0};
    end
    return {t, nroot, rad << 2};
  endfunction

  logic [ROOT_W-1:0] vld_r;
  logic [REM_W-1:0]  rem_r  [0:ROOT_W-2];
  wide_t             rad_r  [0:ROOT_W-2];
  logic [ROOT_W-1:0] root_r [0:ROOT_W-1];
  logic [SB_W-1:0]   sb_r   [0:ROOT_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[ROOT_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sb_r[0] <= in_sb;
      for (int k = 1; k < ROOT_W; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_root;
    wide_t             src_rad;
    logic [STP_W-1:0]  step_nxt;

    if (k == 0) begin : g_first
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_rad  = in_rad;
    end else begin : g_next
      assign src_rem  = rem_r[k-1];
      assign src_root = root_r[k-1];
      assign src_rad  = rad_r[k-1];
    end

    assign step_nxt = sqrt_step(src_rem, src_root, src_rad);

    always_ff @(posedge clk) begin
      if (ce) begin
        root_r[k] <= step_nxt[WIDE_W +: ROOT_W];
      end
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[k] <= step_nxt[WIDE_W+ROOT_W +: REM_W];
          rad_r[k] <= step_nxt[WIDE_W-1:0];
        end
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_sb   = sb_r[ROOT_W-1];

endmodule
`default_nettype wire

>>> hw/rtl/rmj_div_pipe.sv
`default_nettype none
module rmj_div_pipe
  import rmj_pkg::*;
#(
  parameter int LANES = 2,
  parameter int SB_W  = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ce,
  input  logic                    in_vld,
  input  dvd_t  [LANES-1:0]       in_dvd,
  input  wide_t [LANES-1:0]       in_dvs,
  input  logic  [LANES-1:0]       in_neg,
  input  logic  [SB_W-1:0]        in_sb,
  output logic                    out_vld,
  output word_t [LANES-1:0]       out_quo,
  output logic  [SB_W-1:0]        out_sb
);

  localparam int STP_W = WIDE_W + QUO_W;

  // restoring step; quotient bits shift in where dividend bits leave
  function automatic logic [STP_W-1:0] div_step(input wide_t rem,
                                                input logic [QUO_W-1:0] low,
                                                input wide_t dvs);
    logic [WIDE_W:0] t;
    logic            qb;
    t = {rem, low[QUO_W-1]};
    if (t >= {1'b0, dvs}) begin
      t  = t - {1'b0, dvs};
      qb = 1'b1;
    end else begin
      qb = 1'b0;
    end
    return {t[WIDE_W-1:0], low[QUO_W-2:0], qb};
  endfunction

  logic [QUO_W:0]   vld_r;
  wide_t            rem_r [0:QUO_W][0:LANES-1];
  logic [QUO_W-1:0] low_r [0:QUO_W][0:LANES-1];
  wide_t            dvs_r [0:QUO_W][0:LANES-1];
  logic             neg_r [0:QUO_W][0:LANES-1];
  logic             ovf_r [0:QUO_W][0:LANES-1];
  logic [SB_W-1:0]  sb_r  [0:QUO_W];
  word_t            quo_r [0:LANES-1];
  logic             fin_vld_r;
  logic [SB_W-1:0]  fin_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      fin_vld_r <= 1'b0;
    end else if (ce) begin
      vld_r     <= {vld_r[QUO_W-1:0], in_vld};
      fin_vld_r <= vld_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sb_r[0] <= in_sb;
      for (int k = 1; k <= QUO_W; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
      fin_sb_r <= sb_r[QUO_W];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    // quotient of 2^QUO_W or more always saturates
    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[0][l] <= wide_t'(in_dvd[l] >> QUO_W);
        low_r[0][l] <= in_dvd[l][QUO_W-1:0];
        dvs_r[0][l] <= in_dvs[l];
        neg_r[0][l] <= in_neg[l];
        ovf_r[0][l] <= (in_dvd[l] >> QUO_W) >= dvd_t'(in_dvs[l]);
      end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
      logic [STP_W-1:0] step_nxt;
      assign step_nxt = div_step(rem_r[k-1][l], low_r[k-1][l], dvs_r[k-1][l]);
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[k][l] <= step_nxt[QUO_W +: WIDE_W];
          low_r[k][l] <= step_nxt[QUO_W-1:0];
          dvs_r[k][l] <= dvs_r[k-1][l];
          neg_r[k][l] <= neg_r[k-1][l];
          ovf_r[k][l] <= ovf_r[k-1][l];
        end
      end
    end

    logic [QUO_W-1:0] lim_w;
    logic [QUO_W-1:0] mag_w;
    word_t            quo_nxt;

    always_comb begin
      lim_w   = neg_r[QUO_W][l] ? {1'b0, NEG_LIM} : {1'b0, POS_LIM};
      mag_w   = (ovf_r[QUO_W][l] || (low_r[QUO_W][l] > lim_w)) ? lim_w : low_r[QUO_W][l];
      quo_nxt = neg_r[QUO_W][l] ? word_t'(-mag_w) : word_t'(mag_w);
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        quo_r[l] <= quo_nxt;
      end
    end

    assign out_quo[l] = quo_r[l];
  end

  assign out_vld = fin_vld_r;
  assign out_sb  = fin_sb_r;

endmodule
`default_nettype wire

>>> hw/rtl/radar_measurement_jacobian_unit.sv
`default_nettype none
// Radar measurement Jacobian: one state word (pos_x, pos_y, vel_x, vel_y,
// signed Q.FRAC_BITS) in, one word of six Jacobian entries plus a
// divide_by_zero flag out.
// Channels: in_* and out_* use valid/stall; a word moves on a clock edge
// with valid high and stall low. cfg_wr_en writes zero_threshold (raw,
// compared against the squared range with 2*FRAC_BITS fraction bits).
// The pipeline has 2 product/sum stages, a 32-stage square root
// (one root bit per stage), a 35-stage bank of four dividers, 3 stages
// for the range-rate numerators, a second 35-stage bank of two dividers,
// and the output register. A divider's step stages each retire one
// quotient bit. Throughput: one word per cycle while not frozen by out_stall.
// Reset (rst_n low, synchronous) empties the pipeline and loads the
// threshold with its default; no clearing pass is needed.
// When out_stall holds a valid output word, the whole pipeline freezes and
// in_stall goes high; nothing is dropped or repeated. An empty output
// register lets the pipeline advance whatever out_stall says.
module radar_measurement_jacobian_unit
  import rmj_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic        [WORD_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [WORD_W-1:0] in_pos_x,
  input  logic signed [WORD_W-1:0] in_pos_y,
  input  logic signed [WORD_W-1:0] in_vel_x,
  input  logic signed [WORD_W-1:0] in_vel_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_range_dx,
  output logic signed [WORD_W-1:0] out_range_dy,
  output logic signed [WORD_W-1:0] out_bearing_dx,
  output logic signed [WORD_W-1:0] out_bearing_dy,
  output logic signed [WORD_W-1:0] out_rate_dx,
  output logic signed [WORD_W-1:0] out_rate_dy,
  output logic                     out_divide_by_zero
);

  typedef struct packed {
    logic               zf;
    wide_t              r2;
    logic signed [63:0] d;
    word_t              mpx;
    word_t              mpy;
    logic               sx;
    logic               sy;
  } sq_sb_t;

  typedef struct packed {
    logic  zf;
    wide_t r2;
    logic  dneg;
    wide_t md;
  } dv1_sb_t;

  typedef struct packed {
    logic  zf;
    wide_t r2;
    word_t rdx;
    word_t rdy;
    word_t bdx;
    word_t bdy;
    logic  tx_neg;
    logic  ty_neg;
  } mul_t;

  typedef struct packed {
    logic  zf;
    word_t rdx;
    word_t rdy;
    word_t bdx;
    word_t bdy;
  } dv2_sb_t;

  logic  ce;
  word_t thr_r;

  assign ce       = !out_valid || !out_stall;
  assign in_stall = !ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RST;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // stage 1: squares and cross products
  logic signed [WIDE_W-1:0] sqx_nxt, sqy_nxt, pa_nxt, pb_nxt;
  logic signed [WIDE_W-1:0] p1_sqx_r, p1_sqy_r, p1_pa_r, p1_pb_r;
  word_t                    p1_mpx_r, p1_mpy_r;
  logic                     p1_sx_r, p1_sy_r, p1_vld_r;

  always_comb begin
    sqx_nxt = in_pos_x * in_pos_x;
    sqy_nxt = in_pos_y * in_pos_y;
    pa_nxt  = in_vel_x * in_pos_y;
    pb_nxt  = in_vel_y * in_pos_x;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p1_sqx_r <= sqx_nxt;
      p1_sqy_r <= sqy_nxt;
      p1_pa_r  <= pa_nxt;
      p1_pb_r  <= pb_nxt;
      p1_mpx_r <= in_pos_x[WORD_W-1] ? word_t'(-in_pos_x) : word_t'(in_pos_x);
      p1_mpy_r <= in_pos_y[WORD_W-1] ? word_t'(-in_pos_y) : word_t'(in_pos_y);
      p1_sx_r  <= in_pos_x[WORD_W-1];
      p1_sy_r  <= in_pos_y[WORD_W-1];
    end
  end

  // stage 2: squared range, determinant, small-range check
  wide_t  r2_nxt;
  sq_sb_t p2_r;
  logic   p2_vld_r;

  assign r2_nxt = wide_t'(p1_sqx_r) + wide_t'(p1_sqy_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      p2_r.zf  <= (r2_nxt < wide_t'(thr_r)) || (r2_nxt == '0);
      p2_r.r2  <= r2_nxt;
      p2_r.d   <= p1_pa_r - p1_pb_r;
      p2_r.mpx <= p1_mpx_r;
      p2_r.mpy <= p1_mpy_r;
      p2_r.sx  <= p1_sx_r;
      p2_r.sy  <= p1_sy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else if (ce) begin
      p1_vld_r <= in_valid;
      p2_vld_r <= p1_vld_r;
    end
  end

  // range
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  sq_sb_t            sq_sb;

  rmj_sqrt_pipe #(
    .SB_W($bits(sq_sb_t))
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (p2_vld_r),
    .in_rad  (p2_r.r2),
    .in_sb   (p2_r),
    .out_vld (sq_vld),
    .out_root(sq_root),
    .out_sb  (sq_sb)
  );

  // first divider bank: range and bearing entries
  dvd_t    [3:0] dv1_dvd;
  wide_t   [3:0] dv1_dvs;
  logic    [3:0] dv1_neg;
  dv1_sb_t       dv1_in_sb;
  dv1_sb_t       dv1_out_sb;
  word_t   [3:0] dv1_quo;
  logic          dv1_vld;

  always_comb begin
    dv1_dvd[0] = dvd_t'(sq_sb.mpx) << FRAC_BITS;
    dv1_dvd[1] = dvd_t'(sq_sb.mpy) << FRAC_BITS;
    dv1_dvd[2] = dvd_t'(sq_sb.mpy) << (2 * FRAC_BITS);
    dv1_dvd[3] = dvd_t'(sq_sb.mpx) << (2 * FRAC_BITS);
    dv1_dvs[0] = wide_t'(sq_root);
    dv1_dvs[1] = wide_t'(sq_root);
    dv1_dvs[2] = sq_sb.r2;
    dv1_dvs[3] = sq_sb.r2;
    dv1_neg    = {sq_sb.sx, !sq_sb.sy, sq_sb.sy, sq_sb.sx};
    dv1_in_sb.zf   = sq_sb.zf;
    dv1_in_sb.r2   = sq_sb.r2;
    dv1_in_sb.dneg = sq_sb.d[WIDE_W-1];
    dv1_in_sb.md   = sq_sb.d[WIDE_W-1] ? wide_t'(-sq_sb.d) : wide_t'(sq_sb.d);
  end

  rmj_div_pipe #(
    .LANES(4),
    .SB_W ($bits(dv1_sb_t))
  ) u_div_rb (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .in_vld (sq_vld),
    .in_dvd (dv1_dvd),
    .in_dvs (dv1_dvs),
    .in_neg (dv1_neg),
    .in_sb  (dv1_in_sb),
    .out_vld(dv1_vld),
    .out_quo(dv1_quo),
    .out_sb (dv1_out_sb)
  );

  // range-rate numerators: |range entry| * |d|, in two 32x32 halves
  mul_t  m0_r, m1_r, m2_r;
  word_t m0_ax_r, m0_ay_r;
  wide_t m0_md_r;
  wide_t m1_plx_r, m1_phx_r, m1_ply_r, m1_phy_r;
  dvd_t  m2_prx_r, m2_pry_r;
  logic  m0_vld_r, m1_vld_r, m2_vld_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      m0_r.zf     <= dv1_out_sb.zf;
      m0_r.r2     <= dv1_out_sb.r2;
      m0_r.rdx    <= dv1_quo[0];
      m0_r.rdy    <= dv1_quo[1];
      m0_r.bdx    <= dv1_quo[2];
      m0_r.bdy    <= dv1_quo[3];
      m0_r.tx_neg <= dv1_quo[1][WORD_W-1] ^ dv1_out_sb.dneg;
      m0_r.ty_neg <= !(dv1_quo[0][WORD_W-1] ^ dv1_out_sb.dneg);
      m0_ax_r     <= dv1_quo[0][WORD_W-1] ? word_t'(-dv1_quo[0]) : dv1_quo[0];
      m0_ay_r     <= dv1_quo[1][WORD_W-1] ? word_t'(-dv1_quo[1]) : dv1_quo[1];
      m0_md_r     <= dv1_out_sb.md;

      m1_r     <= m0_r;
      m1_plx_r <= wide_t'(m0_ax_r) * wide_t'(m0_md_r[WORD_W-1:0]);
      m1_phx_r <= wide_t'(m0_ax_r) * wide_t'(m0_md_r[WIDE_W-1:WORD_W]);
      m1_ply_r <= wide_t'(m0_ay_r) * wide_t'(m0_md_r[WORD_W-1:0]);
      m1_phy_r <= wide_t'(m0_ay_r) * wide_t'(m0_md_r[WIDE_W-1:WORD_W]);

      m2_r     <= m1_r;
      m2_prx_r <= (dvd_t'(m1_phx_r) << WORD_W) + dvd_t'(m1_plx_r);
      m2_pry_r <= (dvd_t'(m1_phy_r) << WORD_W) + dvd_t'(m1_ply_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m0_vld_r <= 1'b0;
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
    end else if (ce) begin
      m0_vld_r <= dv1_vld;
      m1_vld_r <= m0_vld_r;
      m2_vld_r <= m1_vld_r;
    end
  end

  // second divider bank: range-rate entries
  dvd_t    [1:0] dv2_dvd;
  wide_t   [1:0] dv2_dvs;
  logic    [1:0] dv2_neg;
  dv2_sb_t       dv2_in_sb;
  dv2_sb_t       dv2_out_sb;
  word_t   [1:0] dv2_quo;
  logic          dv2_vld;

  always_comb begin
    dv2_dvd[0] = m2_pry_r;
    dv2_dvd[1] = m2_prx_r;
    dv2_dvs[0] = m2_r.r2;
    dv2_dvs[1] = m2_r.r2;
    dv2_neg    = {m2_r.ty_neg, m2_r.tx_neg};
    dv2_in_sb.zf  = m2_r.zf;
    dv2_in_sb.rdx = m2_r.rdx;
    dv2_in_sb.rdy = m2_r.rdy;
    dv2_in_sb.bdx = m2_r.bdx;
    dv2_in_sb.bdy = m2_r.bdy;
  end

  rmj_div_pipe #(
    .LANES(2),
    .SB_W ($bits(dv2_sb_t))
  ) u_div_rate (
    .clk    (clk),
    .rst_n  (rst_n),
    .ce     (ce),
    .in_vld (m2_vld_r),
    .in_dvd (dv2_dvd),
    .in_dvs (dv2_dvs),
    .in_neg (dv2_neg),
    .in_sb  (dv2_in_sb),
    .out_vld(dv2_vld),
    .out_quo(dv2_quo),
    .out_sb (dv2_out_sb)
  );

  // output register; small range forces every entry to zero
  logic  out_vld_r, out_zf_r;
  word_t out_rdx_r, out_rdy_r, out_bdx_r, out_bdy_r, out_tdx_r, out_tdy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= dv2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_zf_r  <= dv2_out_sb.zf;
      out_rdx_r <= dv2_out_sb.zf ? '0 : dv2_out_sb.rdx;
      out_rdy_r <= dv2_out_sb.zf ? '0 : dv2_out_sb.rdy;
      out_bdx_r <= dv2_out_sb.zf ? '0 : dv2_out_sb.bdx;
      out_bdy_r <= dv2_out_sb.zf ? '0 : dv2_out_sb.bdy;
      out_tdx_r <= dv2_out_sb.zf ? '0 : dv2_quo[0];
      out_tdy_r <= dv2_out_sb.zf ? '0 : dv2_quo[1];
    end
  end

  assign out_valid          = out_vld_r;
  assign out_range_dx       = out_rdx_r;
  assign out_range_dy       = out_rdy_r;
  assign out_bearing_dx     = out_bdx_r;
  assign out_bearing_dy     = out_bdy_r;
  assign out_rate_dx        = out_tdx_r;
  assign out_rate_dy        = out_tdy_r;
  assign out_divide_by_zero = out_zf_r;

endmodule
`default_nettype wire

>>> hw/rtl/rmj_checker.sv
`default_nettype none
module rmj_checker
  import rmj_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_stall,
  input logic  out_valid,
  input logic  out_stall,
  input word_t out_range_dx,
  input word_t out_range_dy,
  input word_t out_bearing_dx,
  input word_t out_bearing_dy,
  input word_t out_rate_dx,
  input word_t out_rate_dy,
  input logic  out_divide_by_zero
);

  // input side only backs up when the output word is held
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a held output word");

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |->
      (out_range_dx == '0) && (out_range_dy == '0) && (out_bearing_dx == '0) &&
      (out_bearing_dy == '0) && (out_rate_dx == '0) && (out_rate_dy == '0))
    else $error("nonzero entry with divide_by_zero set");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("output word dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_range_dx) && $stable(out_rate_dy) &&
                                  $stable(out_divide_by_zero)))
    else $error("output word changed under stall");

endmodule

bind radar_measurement_jacobian_unit rmj_checker u_rmj_checker (.*);
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import rmj_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = 108;

  typedef struct packed {
    word_t rdx, rdy, bdx, bdy, tdx, tdy;
    logic  dbz;
  } jac_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  word_t cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  word_t in_pos_x = '0, in_pos_y = '0, in_vel_x = '0, in_vel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t out_range_dx, out_range_dy, out_bearing_dx, out_bearing_dy;
  word_t out_rate_dx, out_rate_dy;
  logic out_divide_by_zero;

  word_t threshold = THR_RST;
  jac_t jac_queue[$];
  int mismatches = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  radar_measurement_jacobian_unit #(.FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_vel_x(in_vel_x), .in_vel_y(in_vel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_range_dx(out_range_dx), .out_range_dy(out_range_dy),
    .out_bearing_dx(out_bearing_dx), .out_bearing_dy(out_bearing_dy),
    .out_rate_dx(out_rate_dx), .out_rate_dy(out_rate_dy),
    .out_divide_by_zero(out_divide_by_zero)
  );

  // truncated quotient of a signed numerator, saturated to 32 bits
  function automatic word_t sat_quot(logic neg, logic [127:0] num, logic [63:0] den);
    logic [127:0] q;
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    q = num / {64'd0, den};
    if (q > lim) q = lim;
    return neg ? word_t'(-q[31:0]) : q[31:0];
  endfunction

  function automatic jac_t jacobian(word_t px, word_t py, word_t vx, word_t vy);
    jac_t j;
    logic [63:0] mpx, mpy, r2, r, md, bitv;
    logic signed [63:0] d;
    logic dneg;
    j = '0;
    mpx = px[31] ? 64'(-$signed(px)) : 64'(px);
    mpy = py[31] ? 64'(-$signed(py)) : 64'(py);
    r2 = mpx * mpx + mpy * mpy;
    if (r2 < {32'd0, threshold} || r2 == 0) begin
      j.dbz = 1'b1;
      return j;
    end
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      bitv = r | (64'd1 << b);
      if (bitv * bitv <= r2) r = bitv;
    end
    j.rdx = sat_quot(px[31], 128'(mpx) << FB, r);
    j.rdy = sat_quot(py[31], 128'(mpy) << FB, r);
    j.bdx = sat_quot(!py[31], 128'(mpy) << (2 * FB), r2);
    j.bdy = sat_quot(px[31], 128'(mpx) << (2 * FB), r2);
    d = 64'($signed(vx)) * 64'($signed(py)) - 64'($signed(vy)) * 64'($signed(px));
    dneg = d < 0;
    md = dneg ? 64'(-d) : 64'(d);
    j.tdx = sat_quot(j.rdy[31] != dneg,
                     128'(j.rdy[31] ? 32'(-$signed(j.rdy)) : j.rdy) * 128'(md), r2);
    j.tdy = sat_quot(j.rdx[31] == dneg,
                     128'(j.rdx[31] ? 32'(-$signed(j.rdx)) : j.rdx) * 128'(md), r2);
    return j;
  endfunction

  task automatic send_word(word_t px, word_t py, word_t vx, word_t vy);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_vel_x <= vx;
    in_vel_y <= vy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    jac_queue.push_back(jacobian(px, py, vx, vy));
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (jac_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_threshold(word_t v);
    drain_pipe();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = v;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    jac_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_range_dx, out_range_dy, out_bearing_dx, out_bearing_dy,
              out_rate_dx, out_rate_dy, out_divide_by_zero};
      if (jac_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = jac_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h %h %h %h %h %h %b / got %h %h %h %h %h %h %b",
                     want.rdx, want.rdy, want.bdx, want.bdy, want.tdx, want.tdy,
                     want.dbz, got.rdx, got.rdy, got.bdx, got.bdy, got.tdx,
                     got.tdy, got.dbz);
        end
      end
    end
  end

  function automatic word_t rnd_field();
    case ($urandom_range(4))
      0: return $urandom;
      1: return word_t'($signed($urandom_range(8 << FB)) - (4 << FB));
      2: return word_t'($signed($urandom_range(2000)) - 1000);
      3: return $urandom_range(1) ? POS_LIM : NEG_LIM;
      default: return word_t'($signed($urandom_range(400 << FB)) - (200 << FB));
    endcase
  endfunction

  task automatic test_extremes();
    word_t vals[6];
    vals = '{32'd0, 32'd1, POS_LIM, NEG_LIM, 32'hffff_ffff, 32'h0001_0000};
    for (int i = 0; i < 6; i++)
      send_word(vals[i], vals[(i + 2) % 6], vals[(i + 3) % 6], vals[(i + 5) % 6]);
    send_word(32'd0, 32'd0, POS_LIM, NEG_LIM);          // zero range
    send_word(32'd200, 32'd0, 32'd5, 32'd7);            // just below threshold
    send_word(32'd208, 32'd0, 32'd5, 32'd7);            // just above threshold
    send_word(32'd1, 32'd1, POS_LIM, NEG_LIM);          // tiny range, below threshold
    send_word(NEG_LIM, NEG_LIM, NEG_LIM, POS_LIM);
    send_word(32'h0003_0000, 32'hfffc_0000, 32'h0001_0000, 32'h0002_0000);
  endtask

  task automatic test_threshold_zero();
    write_threshold(32'd0);
    send_word(32'd0, 32'd0, 32'd3, 32'd4);
    send_word(32'd1, 32'd0, 32'd3, 32'd4);
    send_word(32'hffff_ffff, 32'd1, POS_LIM, 32'd1);
  endtask

  task automatic test_threshold_max();
    write_threshold(32'hffff_ffff);
    send_word(32'h0001_0000, 32'd0, 32'd1, 32'd1);
    send_word(32'h0000_ffff, 32'd0, 32'd1, 32'd1);
    send_word(32'h0001_0000, 32'h0000_0001, 32'd1, 32'd1);
    for (int i = 0; i < 20; i++) send_word(rnd_field(), rnd_field(), $urandom, $urandom);
  endtask

  task automatic test_random(int n, word_t thr);
    write_threshold(thr);
    for (int i = 0; i < n; i++) send_word(rnd_field(), rnd_field(), rnd_field(), rnd_field());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_idle_pct = 19;
    rcv_idle_pct = 76;
    test_extremes();
    test_threshold_zero();
    test_threshold_max();
    test_random(170, THR_RST);
    snd_idle_pct = 76;
    rcv_idle_pct = 19;
    test_random(170, $urandom_range(1 << 24));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random(170, $urandom);
    drain_pipe();
    if (mismatches == 0 && jac_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> radar_measurement_jacobian_unit.f
hw/rtl/rmj_pkg.sv
hw/rtl/rmj_sqrt_pipe.sv
hw/rtl/rmj_div_pipe.sv
hw/rtl/radar_measurement_jacobian_unit.sv
hw/rtl/rmj_checker.sv
verif/tb_top.sv
